// ===== rtl/prpc_pkg.sv =====
// Shared types, constants and parity helper for the packet receiver.
package prpc_pkg;

	localparam int BUF_BYTES = 64;
	localparam int ADDR_W    = $clog2(BUF_BYTES);

	// result kinds
	localparam logic [2:0] K_SEND  = 3'd0;
	localparam logic [2:0] K_DATA  = 3'd1;
	localparam logic [2:0] K_ACK   = 3'd2;
	localparam logic [2:0] K_NACK  = 3'd3;
	localparam logic [2:0] K_RESET = 3'd4;

	// register indexes
	localparam logic [2:0] R_ACK      = 3'd0;
	localparam logic [2:0] R_NACK     = 3'd1;
	localparam logic [2:0] R_RESET    = 3'd2;
	localparam logic [2:0] R_ACKRESET = 3'd3;
	localparam logic [2:0] R_TIMEOUT  = 3'd4;

	localparam logic [7:0] MASKS [5][4] = '{
		'{8'hc0, 8'hc3, 8'hff, 8'h09},
		'{8'h38, 8'h3a, 8'h7e, 8'h13},
		'{8'h26, 8'hb5, 8'hb9, 8'h23},
		'{8'h95, 8'h6c, 8'hd5, 8'h43},
		'{8'h4b, 8'hdc, 8'he2, 8'h83}};

	typedef enum logic [1:0] {J_ACK, J_NACK, J_RESET, J_FRAME} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [6:0] len;
	} job_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
		logic       last;
	} result_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	typedef struct packed {
		logic [7:0]  ack_code;
		logic [7:0]  nack_code;
		logic [7:0]  reset_code;
		logic [7:0]  ackreset_code;
		logic [23:0] timeout_ticks;
	} cfg_t;

	// five masked parities of one byte at position p of a group
	function automatic logic [4:0] par_bits(input logic [7:0] b, input logic [1:0] p);
		logic [4:0] r;
		for (int k = 0; k < 5; k++) begin
			r[k] = ^(b & MASKS[k][p]);
		end
		return r;
	endfunction

endpackage

// ===== rtl/prpc_jobq.sv =====
// Two-entry queue of classified requests between front and back.
module prpc_jobq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  prpc_pkg::job_t wdata,
	input  logic          rd,
	output prpc_pkg::job_t rdata,
	output logic          full,
	output logic          empty
);
	prpc_pkg::job_t ent_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) ent_q[wp_q] <= wdata;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

// ===== rtl/prpc_outq.sv =====
// Four-entry result queue driving the output side.
module prpc_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  prpc_pkg::result_t wdata,
	input  logic              rd,
	output prpc_pkg::result_t rdata,
	output logic              full,
	output logic              empty
);
	prpc_pkg::result_t ent_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full  = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign rdata = ent_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) ent_q[wp_q] <= wdata;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 2'd0;
			rp_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
		end
	end
endmodule

// ===== rtl/prpc_front.sv =====
// Front end: takes bytes and ticks, fills the frame store, queues requests.
module prpc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                mode,
	input  logic [7:0]          rx_byte,
	input  prpc_pkg::cfg_t      cfg,
	input  logic                frame_done,
	input  logic                jq_full,
	output logic                busy,
	output logic                jq_wr,
	output prpc_pkg::job_t      jq_data,
	output prpc_pkg::mem_wr_t   mem_wr
);
	logic [6:0]  fill_q, len_q, total_q;
	logic [23:0] idle_q;
	logic        busy_q;

	logic [7:0]  x3;
	logic [13:0] prod;
	logic [7:0]  hdr_total;
	logic [6:0]  nfill;
	logic [23:0] nidle;

	assign busy = busy_q | jq_full;

	// header size: len + ceil(len/3), ceil by reciprocal multiply
	always_comb begin
		x3 = {1'b0, rx_byte[6:0]} + 8'd2;
		prod = {6'd0, x3} * 14'd43;
		hdr_total = {1'b0, rx_byte[6:0]} + {1'b0, prod[13:7]};
		nfill = fill_q + 7'd1;
		nidle = (idle_q == 24'hffffff) ? idle_q : idle_q + 24'd1;
	end

	// request and store-write decode
	always_comb begin
		jq_wr = 1'b0;
		jq_data.kind = prpc_pkg::J_FRAME;
		jq_data.len = len_q;
		mem_wr.en = 1'b0;
		mem_wr.addr = fill_q[prpc_pkg::ADDR_W-1:0];
		mem_wr.data = rx_byte;
		if (take && !mode) begin
			if (fill_q == 7'd0) begin
				mem_wr.addr = '0;
				if (rx_byte == cfg.ack_code) begin
					jq_wr = 1'b1;
					jq_data.kind = prpc_pkg::J_ACK;
				end else if (rx_byte == cfg.nack_code) begin
					jq_wr = 1'b1;
					jq_data.kind = prpc_pkg::J_NACK;
				end else if (rx_byte == cfg.reset_code) begin
					jq_wr = 1'b1;
					jq_data.kind = prpc_pkg::J_RESET;
				end else if (hdr_total <= 8'(prpc_pkg::BUF_BYTES)) begin
					mem_wr.en = 1'b1;
					// zero length closes at once
					if (hdr_total == 8'd0) begin
						jq_wr = 1'b1;
						jq_data.len = 7'd0;
					end
				end
			end else begin
				mem_wr.en = 1'b1;
				if (nfill >= total_q) jq_wr = 1'b1;
			end
		end
	end

	// frame fill state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 7'd0;
			len_q <= 7'd0;
			total_q <= 7'd0;
			idle_q <= 24'd0;
			busy_q <= 1'b0;
		end else begin
			if (frame_done) busy_q <= 1'b0;
			if (take && mode) begin
				if (fill_q != 7'd0) begin
					if (nidle >= cfg.timeout_ticks) begin
						fill_q <= 7'd0;
						idle_q <= 24'd0;
					end else begin
						idle_q <= nidle;
					end
				end
			end else if (take) begin
				idle_q <= 24'd0;
				if (fill_q == 7'd0) begin
					if (mem_wr.en) begin
						len_q <= rx_byte[6:0];
						total_q <= hdr_total[6:0];
						if (jq_wr) begin
							busy_q <= 1'b1;
						end else begin
							fill_q <= 7'd1;
						end
					end
				end else if (jq_wr) begin
					fill_q <= 7'd0;
					busy_q <= 1'b1;
				end else begin
					fill_q <= nfill;
				end
			end
		end
	end
endmodule

// ===== rtl/prpc_back.sv =====
// Back end: frame store, group checks, toggle test and result generation.
module prpc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  prpc_pkg::cfg_t    cfg,
	input  prpc_pkg::mem_wr_t mem_wr,
	input  logic              jq_empty,
	input  prpc_pkg::job_t    jq_data,
	output logic              jq_rd,
	input  logic              oq_full,
	output logic              oq_wr,
	output prpc_pkg::result_t oq_data,
	output logic              frame_done
);
	typedef enum logic [3:0] {
		B_IDLE, B_EV1, B_EV2, B_NACK, B_ACK,
		B_CHK_ADDR, B_CHK_WAIT, B_CHK_DATA,
		B_TGL_ADDR, B_TGL_WAIT, B_TGL_DATA,
		B_OUT_ADDR, B_OUT_WAIT, B_OUT_DATA
	} state_t;

	localparam int AW = prpc_pkg::ADDR_W;

	state_t state_q;
	logic [7:0]    mem_q [prpc_pkg::BUF_BYTES];
	logic [AW-1:0] raddr_q;
	logic [7:0]    rdata_q;
	prpc_pkg::job_kind_t ev_q;
	logic [6:0] len_q;
	logic [4:0] t_q;
	logic [5:0] base_q;
	logic [1:0] ph_q;
	logic [4:0] par_q;
	logic [5:0] idx_q;
	logic       tgl_q;

	logic [4:0] npar;
	logic [6:0] next_base;

	// frame store: front writes, back reads with a registered port
	always_ff @(posedge clk) begin
		if (mem_wr.en) mem_q[mem_wr.addr] <= mem_wr.data;
		rdata_q <= mem_q[raddr_q];
	end

	always_comb begin
		npar = par_q ^ prpc_pkg::par_bits(rdata_q, ph_q);
		next_base = {1'b0, base_q} + 7'd3;
	end

	// result drive
	always_comb begin
		jq_rd = (state_q == B_IDLE) && !jq_empty;
		oq_wr = 1'b0;
		oq_data.kind = prpc_pkg::K_SEND;
		oq_data.value = 8'd0;
		oq_data.last = 1'b1;
		frame_done = 1'b0;
		unique case (state_q)
			B_EV1: begin
				oq_wr = !oq_full;
				unique case (ev_q)
					prpc_pkg::J_ACK:  oq_data.kind = prpc_pkg::K_ACK;
					prpc_pkg::J_NACK: oq_data.kind = prpc_pkg::K_NACK;
					default: begin
						oq_data.kind = prpc_pkg::K_RESET;
						oq_data.last = 1'b0;
					end
				endcase
			end
			B_EV2: begin
				oq_wr = !oq_full;
				oq_data.value = cfg.ackreset_code;
			end
			B_NACK: begin
				oq_wr = !oq_full;
				oq_data.value = cfg.nack_code;
				frame_done = !oq_full;
			end
			B_ACK: begin
				oq_wr = !oq_full;
				oq_data.value = cfg.ack_code;
				frame_done = !oq_full;
			end
			B_OUT_DATA: begin
				oq_wr = !oq_full;
				oq_data.kind = prpc_pkg::K_DATA;
				oq_data.value = (idx_q == 6'd1) ? {1'b0, rdata_q[6:0]} : rdata_q;
				oq_data.last = ({1'b0, idx_q} + 7'd1 == len_q);
				frame_done = !oq_full && oq_data.last;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			tgl_q <= 1'b0;
			raddr_q <= '0;
			ev_q <= prpc_pkg::J_ACK;
			len_q <= 7'd0;
			t_q <= 5'd0;
			base_q <= 6'd0;
			ph_q <= 2'd0;
			par_q <= 5'd0;
			idx_q <= 6'd0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!jq_empty) begin
						ev_q <= jq_data.kind;
						len_q <= jq_data.len;
						t_q <= 5'd0;
						base_q <= 6'd0;
						ph_q <= 2'd0;
						par_q <= 5'd0;
						if (jq_data.kind != prpc_pkg::J_FRAME) begin
							state_q <= B_EV1;
						end else if (jq_data.len < 7'd2 || jq_data.len == 7'd4) begin
							state_q <= B_NACK;
						end else begin
							state_q <= B_CHK_ADDR;
						end
					end
				end
				B_EV1: begin
					if (!oq_full) begin
						state_q <= (ev_q == prpc_pkg::J_RESET) ? B_EV2 : B_IDLE;
					end
				end
				B_EV2, B_NACK, B_ACK: begin
					if (!oq_full) state_q <= B_IDLE;
				end
				B_CHK_ADDR: begin
					if (ph_q == 2'd3) begin
						raddr_q <= AW'(len_q + {2'd0, t_q});
					end else begin
						raddr_q <= AW'(base_q + {4'd0, ph_q});
					end
					state_q <= B_CHK_WAIT;
				end
				B_CHK_WAIT: state_q <= B_CHK_DATA;
				B_CHK_DATA: begin
					if (ph_q == 2'd3) begin
						if (rdata_q[2:0] != t_q[2:0] || npar != 5'd0) begin
							state_q <= B_NACK;
						end else begin
							t_q <= t_q + 5'd1;
							base_q <= next_base[5:0];
							ph_q <= 2'd0;
							par_q <= 5'd0;
							state_q <= (next_base >= len_q) ? B_TGL_ADDR : B_CHK_ADDR;
						end
					end else begin
						ph_q <= ph_q + 2'd1;
						par_q <= npar;
						state_q <= B_CHK_ADDR;
					end
				end
				B_TGL_ADDR: begin
					raddr_q <= AW'(1);
					state_q <= B_TGL_WAIT;
				end
				B_TGL_WAIT: state_q <= B_TGL_DATA;
				B_TGL_DATA: begin
					if (rdata_q[7] != tgl_q) begin
						state_q <= B_ACK;
					end else begin
						tgl_q <= ~tgl_q;
						idx_q <= 6'd0;
						state_q <= B_OUT_ADDR;
					end
				end
				B_OUT_ADDR: begin
					raddr_q <= idx_q[AW-1:0];
					state_q <= B_OUT_WAIT;
				end
				B_OUT_WAIT: state_q <= B_OUT_DATA;
				B_OUT_DATA: begin
					if (!oq_full) begin
						if (oq_data.last) begin
							state_q <= B_IDLE;
						end else begin
							idx_q <= idx_q + 6'd1;
							state_q <= B_OUT_ADDR;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/packet_receiver_parity_check_core.sv =====
// Top level: config registers, front end, request queue, back end, result queue.
//
//  channel | handshake        | payload
//  input   | push / full      | mode, rx_byte
//  result  | pop / empty      | kind, value, last
//  config  | cfg_wr_en        | cfg_index, cfg_data
//
// Ticks and frame bytes are taken while full is low. A frame that completes
// holds full high while the back end checks it and emits its result, reading
// the frame store through its single registered read port. Ack and nack
// requests give one result each, reset gives two. Reset clears all control
// state; a full result queue stalls the back end and can thus keep full high.
module packet_receiver_parity_check_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [7:0]  value,
	output logic        last,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	prpc_pkg::cfg_t    cfg_q;
	prpc_pkg::job_t    jq_wdata, jq_rdata;
	prpc_pkg::mem_wr_t mem_wr;
	prpc_pkg::result_t oq_wdata, oq_rdata;
	logic take, jq_wr, jq_rd, jq_full, jq_empty, oq_wr, oq_full, frame_done;

	assign take  = push && !full;
	assign kind  = oq_rdata.kind;
	assign value = oq_rdata.value;
	assign last  = oq_rdata.last;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_code <= 8'h80;
			cfg_q.nack_code <= 8'he1;
			cfg_q.reset_code <= 8'hd2;
			cfg_q.ackreset_code <= 8'hb3;
			cfg_q.timeout_ticks <= 24'd100000;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				prpc_pkg::R_ACK:      cfg_q.ack_code <= cfg_data[7:0];
				prpc_pkg::R_NACK:     cfg_q.nack_code <= cfg_data[7:0];
				prpc_pkg::R_RESET:    cfg_q.reset_code <= cfg_data[7:0];
				prpc_pkg::R_ACKRESET: cfg_q.ackreset_code <= cfg_data[7:0];
				prpc_pkg::R_TIMEOUT:  cfg_q.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	prpc_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .mode(mode), .rx_byte(rx_byte),
		.cfg(cfg_q), .frame_done(frame_done), .jq_full(jq_full), .busy(full),
		.jq_wr(jq_wr), .jq_data(jq_wdata), .mem_wr(mem_wr)
	);

	prpc_jobq u_jobq (
		.clk(clk), .arst_n(arst_n), .wr(jq_wr), .wdata(jq_wdata), .rd(jq_rd),
		.rdata(jq_rdata), .full(jq_full), .empty(jq_empty)
	);

	prpc_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .mem_wr(mem_wr),
		.jq_empty(jq_empty), .jq_data(jq_rdata), .jq_rd(jq_rd),
		.oq_full(oq_full), .oq_wr(oq_wr), .oq_data(oq_wdata), .frame_done(frame_done)
	);

	prpc_outq u_outq (
		.clk(clk), .arst_n(arst_n), .wr(oq_wr), .wdata(oq_wdata), .rd(pop && !empty),
		.rdata(oq_rdata), .full(oq_full), .empty(empty)
	);
endmodule

// ===== tb/packet_receiver_parity_check_core_tb.sv =====
// Testbench for the packet receiver core: directed and random requests, checked by a predictor.
module packet_receiver_parity_check_core_tb;
	import prpc_pkg::*;

	localparam int CLEAR_WAIT = 400;   // covers a full 48-byte frame walk in the back end
	localparam int STALL_LIMIT = 20000;
	localparam int ITEM_GOAL = 470;
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        mode;
	logic [7:0]  rx_byte;
	logic        empty;
	logic        pop;
	logic [2:0]  kind;
	logic [7:0]  value;
	logic        last;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	packet_receiver_parity_check_core dut (.*);

	// receiver state as predicted
	logic [7:0]  rx_frame [BUF_BYTES];
	int          rx_fill;
	int          rx_len;
	logic        rx_toggle;
	logic [23:0] rx_idle;
	cfg_t        regs;

	result_t replies_due [$];
	int      mismatches;
	int      items_sent;
	int      cycle_no;
	int      last_activity;
	bit      no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int frame_total(int len);
		return len + (len + 2) / 3;
	endfunction

	function automatic logic [7:0] frame_byte(int i);
		return (i < BUF_BYTES) ? rx_frame[i] : 8'h00;
	endfunction

	// one check group: sequence number and five masked parities
	function automatic bit group_ok(int len, int t);
		logic [7:0] chk;
		logic       x;
		chk = frame_byte(len + t);
		if (chk[2:0] != t[2:0]) return 1'b0;
		for (int k = 0; k < 5; k++) begin
			x = ^(chk & MASKS[k][3]);
			for (int p = 0; p < 3; p++) x ^= ^(frame_byte(3 * t + p) & MASKS[k][p]);
			if (x) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void add_reply(logic [2:0] k, logic [7:0] v);
		result_t r;
		r.kind = k;
		r.value = v;
		r.last = 1'b0;
		replies_due.push_back(r);
	endfunction

	function automatic void close_frame();
		bit good;
		logic [7:0] b;
		rx_fill = 0;
		rx_idle = '0;
		good = !(rx_len < 2 || rx_len == 4);
		if (good) begin
			for (int t = 0; t < (rx_len + 2) / 3; t++) if (!group_ok(rx_len, t)) good = 1'b0;
		end
		b = frame_byte(1);
		if (!good) add_reply(K_SEND, regs.nack_code);
		else if (b[7] != rx_toggle) add_reply(K_SEND, regs.ack_code);
		else begin
			rx_toggle = ~rx_toggle;
			for (int i = 0; i < rx_len; i++) begin
				b = frame_byte(i);
				if (i == 1) b[7] = 1'b0;
				add_reply(K_DATA, b);
			end
		end
	endfunction

	// expected replies for one accepted request
	function automatic void predict_rx(logic m, logic [7:0] b);
		int size_in;
		size_in = replies_due.size();
		if (m == MODE_TICK) begin
			if (rx_fill > 0) begin
				if (rx_idle != 24'hffffff) rx_idle++;
				if (rx_idle >= regs.timeout_ticks) begin
					rx_fill = 0;
					rx_idle = '0;
				end
			end
		end else if (rx_fill == 0) begin
			if (b == regs.ack_code) add_reply(K_ACK, 8'h00);
			else if (b == regs.nack_code) add_reply(K_NACK, 8'h00);
			else if (b == regs.reset_code) begin
				add_reply(K_RESET, 8'h00);
				add_reply(K_SEND, regs.ackreset_code);
			end else begin
				rx_len = b[6:0];
				if (frame_total(rx_len) > BUF_BYTES) rx_len = 0;
				else begin
					rx_frame[0] = b;
					rx_fill = 1;
					rx_idle = '0;
					if (rx_fill >= frame_total(rx_len)) close_frame();
				end
			end
		end else begin
			if (rx_fill < BUF_BYTES) rx_frame[rx_fill] = b;
			rx_fill++;
			rx_idle = '0;
			if (rx_fill >= frame_total(rx_len)) close_frame();
		end
		if (replies_due.size() > size_in) replies_due[$].last = 1'b1;
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 11);
	endfunction

	// send one request; push stays high across back-to-back requests
	task automatic send_item(logic m, logic [7:0] b);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		mode <= m;
		rx_byte <= b;
		do @(posedge clk); while (full);
		last_activity = cycle_no;
		items_sent++;
		predict_rx(m, b);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		wait (replies_due.size() == 0);
		repeat (CLEAR_WAIT) @(posedge clk);
		last_activity = cycle_no;
	endtask

	task automatic close_open_frame();
		while (rx_fill > 0) send_item(MODE_BYTE, $urandom_range(0, 255));
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] d);
		close_open_frame();
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			R_ACK:      regs.ack_code = d[7:0];
			R_NACK:     regs.nack_code = d[7:0];
			R_RESET:    regs.reset_code = d[7:0];
			R_ACKRESET: regs.ackreset_code = d[7:0];
			R_TIMEOUT:  regs.timeout_ticks = d;
			default: ;
		endcase
	endtask

	function automatic bit is_code(logic [7:0] b);
		return b == regs.ack_code || b == regs.nack_code || b == regs.reset_code;
	endfunction

	// header byte that opens a frame of the given length
	function automatic logic [7:0] header_for(int len);
		logic [7:0] h;
		h = {1'($urandom_range(0, 1)), 7'(len)};
		if (is_code(h)) h[7] = 1'b0;
		return h;
	endfunction

	// build a frame with valid checks; the toggle matches unless dup, one bit flipped if bad
	task automatic send_frame(int len, bit dup, bit bad);
		logic [7:0] fr [$];
		logic [7:0] saved [BUF_BYTES];
		int total;
		int pos;
		total = frame_total(len);
		fr.push_back(header_for(len));
		for (int i = 1; i < total; i++) fr.push_back($urandom_range(0, 255));
		if (len > 1) fr[1][7] = dup ? ~rx_toggle : rx_toggle;
		// solve check bytes on a scratch copy of the store
		saved = rx_frame;
		foreach (fr[i]) if (i < BUF_BYTES) rx_frame[i] = fr[i];
		for (int t = 0; t < (len + 2) / 3; t++) begin
			for (int c = 0; c < 32; c++) begin
				rx_frame[len + t] = {5'(c), 3'(t)};
				if (group_ok(len, t)) break;
			end
		end
		for (int i = 0; i < total && i < BUF_BYTES; i++) fr[i] = rx_frame[i];
		rx_frame = saved;
		if (bad && total > 1) begin
			pos = $urandom_range(1, total - 1);
			fr[pos][$urandom_range(0, 7)] ^= 1'b1;
		end
		foreach (fr[i]) send_item(MODE_BYTE, fr[i]);
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 48;
		if (r < 10) return $urandom_range(0, 127);
		return $urandom_range(2, 12);
	endfunction

	// directed: events, sizes, duplicates, bad checks, ticks
	task automatic test_directed();
		send_item(MODE_BYTE, regs.ack_code);
		send_item(MODE_BYTE, regs.nack_code);
		send_item(MODE_BYTE, regs.reset_code);
		send_item(MODE_TICK, 8'hff);
		send_item(MODE_BYTE, 8'h00);
		send_frame(1, 1'b0, 1'b0);
		send_frame(4, 1'b0, 1'b0);
		send_item(MODE_BYTE, 8'h31);
		send_item(MODE_BYTE, 8'h7f);
		send_frame(2, 1'b0, 1'b0);
		send_frame(48, 1'b0, 1'b0);
		send_frame(3, 1'b1, 1'b0);
		send_frame(5, 1'b0, 1'b1);
		// code value inside an open frame is plain data
		send_item(MODE_BYTE, header_for(2));
		send_item(MODE_BYTE, regs.ack_code);
		send_item(MODE_TICK, 8'h00);
		send_item(MODE_BYTE, regs.reset_code);
	endtask

	// partial frame dropped after the idle limit
	task automatic test_timeout();
		write_reg(R_TIMEOUT, 24'd3);
		send_item(MODE_BYTE, header_for(6));
		send_item(MODE_BYTE, 8'h55);
		repeat (3) send_item(MODE_TICK, $urandom_range(0, 255));
		send_frame(6, 1'b0, 1'b0);
		write_reg(R_TIMEOUT, 24'd1);
		send_item(MODE_BYTE, header_for(3));
		send_item(MODE_TICK, 8'h00);
		send_frame(3, 1'b0, 1'b0);
	endtask

	// code registers at both ends of their upper half, 128 to 255
	task automatic test_code_regs();
		logic [7:0] sets [3][4];
		sets[0] = '{8'd128, 8'd255, 8'd129, 8'd254};
		sets[1] = '{8'd255, 8'd128, 8'd200, 8'd128};
		sets[2] = '{$urandom_range(128, 255), $urandom_range(128, 255),
			$urandom_range(128, 255), $urandom_range(128, 255)};
		for (int s = 0; s < 3; s++) begin
			write_reg(R_ACK, sets[s][0]);
			write_reg(R_NACK, sets[s][1]);
			write_reg(R_RESET, sets[s][2]);
			write_reg(R_ACKRESET, sets[s][3]);
			send_item(MODE_BYTE, regs.ack_code);
			send_item(MODE_BYTE, regs.nack_code);
			send_item(MODE_BYTE, regs.reset_code);
			send_frame(0, 1'b0, 1'b0);
			send_frame($urandom_range(2, 9), 1'b0, 1'b0);
			send_frame(3, 1'b1, 1'b0);
		end
		write_reg(R_TIMEOUT, 24'hffffff);
	endtask

	// random mix, mostly well-formed frames
	task automatic test_random();
		int r;
		bit paused;
		paused = 1'b0;
		while (items_sent < ITEM_GOAL) begin
			if (($urandom_range(0, 15)) == 0) no_idle = ~no_idle;
			if (!paused && items_sent > ITEM_GOAL / 2) begin
				paused = 1'b1;
				drain();
				write_reg(R_TIMEOUT, 24'($urandom_range(2, 8)));
			end
			r = $urandom_range(0, 99);
			if (r < 60) send_frame(pick_len(), $urandom_range(0, 9) == 0,
				$urandom_range(0, 7) == 0);
			else if (r < 75) send_item(MODE_TICK, $urandom_range(0, 255));
			else if (r < 85) begin
				case ($urandom_range(0, 2))
					0: send_item(MODE_BYTE, regs.ack_code);
					1: send_item(MODE_BYTE, regs.nack_code);
					default: send_item(MODE_BYTE, regs.reset_code);
				endcase
			end else send_item(MODE_BYTE, $urandom_range(0, 255));
		end
		no_idle = 1'b0;
	endtask

	// result checker with random stalls
	initial begin
		int stall;
		result_t want;
		stall = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				last_activity = cycle_no;
				if (replies_due.size() == 0) begin
					$error("unexpected result: kind %0d value %0h", kind, value);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						mismatches++;
					end
					if (value !== want.value) begin
						$error("value: expected %0h, got %0h", want.value, value);
						mismatches++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						mismatches++;
					end
				end
				stall = draw_gap();
			end
			pop <= (stall == 0);
			if (stall > 0) stall--;
		end
	end

	// watchdog on cycles without any handshake
	initial begin
		cycle_no = 0;
		last_activity = 0;
		forever begin
			@(posedge clk);
			cycle_no++;
			if (cycle_no - last_activity > STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		mode = MODE_BYTE;
		rx_byte = 8'h00;
		cfg_wr_en = 1'b0;
		cfg_index = R_ACK;
		cfg_data = '0;
		mismatches = 0;
		items_sent = 0;
		no_idle = 1'b0;
		foreach (rx_frame[i]) rx_frame[i] = 8'h00;
		rx_fill = 0;
		rx_len = 0;
		rx_toggle = 1'b0;
		rx_idle = '0;
		regs = '{8'h80, 8'he1, 8'hd2, 8'hb3, 24'd100000};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_timeout();
		test_code_regs();
		test_random();
		drain();
		if (mismatches == 0 && replies_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== packet_receiver_parity_check_core.f =====
rtl/prpc_pkg.sv
rtl/prpc_jobq.sv
rtl/prpc_outq.sv
rtl/prpc_front.sv
rtl/prpc_back.sv
rtl/packet_receiver_parity_check_core.sv
tb/packet_receiver_parity_check_core_tb.sv
